/* rtl/keyed_stack_store_defines.svh */
// Assertion macros shared by the checker files of the keyed stack store.
// Depends on nothing; every use supplies its own clock and reset.
`ifndef KEYED_STACK_STORE_DEFINES_SVH
`define KEYED_STACK_STORE_DEFINES_SVH

// General implication checked on every rising clock edge outside reset.
`define KSS_ASSERT(name, clk, rst_n, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// A stalled transaction keeps its valid and its payload.
`define KSS_ASSERT_HOLD(name, clk, rst_n, vld, stl, data, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) \
		(vld && stl) |=> (vld && $stable(data))) else $error(msg);

`endif

/* rtl/kss_pkg.sv */
// Shared types and constants of the keyed stack store.
// Used by kss_ctrl, keyed_stack_store and kss_checker; depends on nothing.
package kss_pkg;
	localparam int DEPTH = 16;
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam int DW = 64;

	localparam logic [1:0] OP_INSERT = 2'd0;
	localparam logic [1:0] OP_POP = 2'd1;
	localparam logic [1:0] OP_TAKE = 2'd2;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_NOKEY = 2'd2;
	localparam logic [1:0] ST_FULL = 2'd3;

	typedef struct packed {
		logic [1:0] op;
		logic [31:0] cargo_in;
		logic [31:0] key_in;
	} req_t;

	typedef struct packed {
		logic [31:0] cargo_out;
		logic [31:0] key_out;
		logic [1:0] status;
		logic [4:0] entries;
	} rsp_t;
endpackage

/* rtl/kss_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// Self-contained; no package needed.
module kss_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input logic clk,
	input logic wr_en,
	input logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input logic [WIDTH-1:0] wr_data,
	input logic rd_en,
	input logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0] rd_data
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end
endmodule

/* rtl/kss_ctrl.sv */
// Sequencer of the keyed stack store: runs insert, pop and the keyed search
// and close-up against the entry RAM. Depends on kss_pkg and kss_ram.
module kss_ctrl (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	output logic req_stall,
	input kss_pkg::req_t req,
	output logic res_valid,
	input logic res_ready,
	output kss_pkg::rsp_t res
);
	import kss_pkg::*;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_POPW = 3'd1;
	localparam logic [2:0] S_SRD = 3'd2;
	localparam logic [2:0] S_SCMP = 3'd3;
	localparam logic [2:0] S_SHR = 3'd4;
	localparam logic [2:0] S_SHW = 3'd5;
	localparam logic [2:0] S_DONE = 3'd6;

	logic [2:0] state_q;
	logic [CW-1:0] count_q;
	logic [31:0] next_key_q;
	logic [AW-1:0] ptr_q;
	logic [31:0] key_q;
	logic [31:0] cargo_q;
	logic [31:0] key_out_q;
	logic [1:0] status_q;

	logic wr_en, rd_en;
	logic [AW-1:0] wr_addr, rd_addr;
	logic [DW-1:0] wr_data, rd_data;
	logic [AW-1:0] top_idx;
	logic accept;

	assign top_idx = AW'(count_q - CW'(1));
	assign accept = req_valid && (state_q == S_IDLE);
	assign req_stall = (state_q != S_IDLE);

	// Each RAM word holds the key in the upper half and the cargo below.
	always_comb begin
		wr_en = 1'b0;
		wr_addr = ptr_q;
		wr_data = rd_data;
		rd_en = 1'b0;
		rd_addr = ptr_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept && req.op == OP_INSERT && count_q < CW'(DEPTH)) begin
					wr_en = 1'b1;
					wr_addr = top_idx + AW'(1);
					wr_data = {next_key_q, req.cargo_in};
				end
				if (accept && req.op == OP_POP) begin
					rd_en = 1'b1;
					rd_addr = top_idx;
				end
			end
			S_SRD: rd_en = 1'b1;
			S_SHR: begin
				rd_en = 1'b1;
				rd_addr = ptr_q + AW'(1);
			end
			S_SHW: wr_en = 1'b1;
			default: ;
		endcase
	end

	kss_ram #(.WIDTH(DW), .DEPTH(DEPTH)) u_ram (
		.clk(clk),
		.wr_en(wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en(rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			next_key_q <= '0;
			ptr_q <= '0;
			key_q <= '0;
			cargo_q <= '0;
			key_out_q <= '0;
			status_q <= ST_OK;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						cargo_q <= '0;
						key_out_q <= '0;
						status_q <= ST_OK;
						key_q <= req.key_in;
						ptr_q <= top_idx;
						state_q <= S_DONE;
						unique case (req.op)
							OP_INSERT: begin
								if (count_q >= CW'(DEPTH)) begin
									status_q <= ST_FULL;
								end else begin
									key_out_q <= next_key_q;
									next_key_q <= next_key_q + 32'd1;
									count_q <= count_q + CW'(1);
								end
							end
							OP_POP: begin
								if (count_q == '0) status_q <= ST_EMPTY;
								else state_q <= S_POPW;
							end
							OP_TAKE: begin
								if (count_q == '0) status_q <= ST_EMPTY;
								else state_q <= S_SRD;
							end
							default: ;
						endcase
					end
				end
				S_POPW: begin
					cargo_q <= rd_data[31:0];
					count_q <= count_q - CW'(1);
					state_q <= S_DONE;
				end
				S_SRD: state_q <= S_SCMP;
				S_SCMP: begin
					if (rd_data[63:32] == key_q) begin
						cargo_q <= rd_data[31:0];
						if (CW'(ptr_q) + CW'(1) == count_q) begin
							count_q <= count_q - CW'(1);
							state_q <= S_DONE;
						end else begin
							state_q <= S_SHR;
						end
					end else if (ptr_q == '0) begin
						status_q <= ST_NOKEY;
						state_q <= S_DONE;
					end else begin
						ptr_q <= ptr_q - AW'(1);
						state_q <= S_SRD;
					end
				end
				S_SHR: state_q <= S_SHW;
				S_SHW: begin
					ptr_q <= ptr_q + AW'(1);
					if (CW'(ptr_q) + CW'(2) == count_q) begin
						count_q <= count_q - CW'(1);
						state_q <= S_DONE;
					end else begin
						state_q <= S_SHR;
					end
				end
				S_DONE: begin
					if (res_ready) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign res_valid = (state_q == S_DONE);
	always_comb begin
		res.cargo_out = cargo_q;
		res.key_out = key_out_q;
		res.status = status_q;
		res.entries = 5'(count_q);
	end
endmodule

/* rtl/keyed_stack_store.sv */
// Keyed stack store: a last-in-first-out store of up to DEPTH cargo words,
// each tagged with a key from a wrapping 32-bit counter. Insert, an unused op
// code and any transaction refused for a full or empty store go from
// acceptance through the sequencer's result state into the output register;
// pop first reads the top entry. Take-by-key reads and compares one entry at a
// time from the top down and then closes the gap with one read and one write
// per entry above the match. The pace is set by the single entry RAM, which
// gives one read and one write per cycle. One transaction is worked on at a
// time; the next one is accepted no earlier than the cycle after its
// predecessor's result enters the output register, and it may be accepted
// while that result still waits there.
module keyed_stack_store (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	output logic req_stall,
	input kss_pkg::req_t req,
	output logic rsp_valid,
	input logic rsp_stall,
	output kss_pkg::rsp_t rsp
);
	import kss_pkg::*;

	logic res_valid, res_ready;
	rsp_t res;
	logic rsp_valid_q;
	rsp_t rsp_q;

	kss_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res(res)
	);

	assign res_ready = !rsp_valid_q || !rsp_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (res_ready) begin
			rsp_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			rsp_q <= res;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp = rsp_q;
endmodule

/* rtl/kss_checker.sv */
// Port-level checks of the keyed stack store, bound to the top level.
// Depends on kss_pkg and keyed_stack_store_defines.svh.
`include "keyed_stack_store_defines.svh"

module kss_checker (
	input logic clk,
	input logic arst_n,
	input logic rsp_valid,
	input logic rsp_stall,
	input kss_pkg::rsp_t rsp
);
	import kss_pkg::*;

	`KSS_ASSERT_HOLD(a_rsp_hold, clk, arst_n, rsp_valid, rsp_stall, rsp, "stalled result changed")
	`KSS_ASSERT(a_full_count, clk, arst_n, (rsp_valid && rsp.status == ST_FULL) |-> (rsp.entries == 5'(DEPTH)), "full status with wrong count")
	`KSS_ASSERT(a_empty_count, clk, arst_n, (rsp_valid && rsp.status == ST_EMPTY) |-> (rsp.entries == 5'd0), "empty status with entries held")
	`KSS_ASSERT(a_key_or_cargo, clk, arst_n, (rsp_valid && rsp.key_out != 32'd0) |-> (rsp.cargo_out == 32'd0 && rsp.status == ST_OK), "insert result carries cargo")
endmodule

bind keyed_stack_store kss_checker u_kss_checker (.*);

/* tb/sv/tb_keyed_stack_store.sv */
// Self-checking testbench of the keyed stack store: directed table, then random traffic.
// Depends on kss_pkg and the keyed_stack_store module.
`timescale 1ns / 1ps

module tb_keyed_stack_store;
	import kss_pkg::*;

	localparam int CYCLE_LIMIT = 2000000;
	localparam int N_RANDOM = 1200;

	typedef struct {
		req_t req;
		logic has_exp;
		rsp_t exp;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;

	keyed_stack_store uut (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_stall(req_stall), .req(req),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Predictor state: a plain stack of cargo words with their keys.
	logic [31:0] stk_cargo[DEPTH];
	logic [31:0] stk_key[DEPTH];
	int unsigned stk_count = 0;
	logic [31:0] key_counter = '0;

	rsp_t pending_rsp[$];
	int errors = 0;
	int cycles = 0;
	int n_rsp = 0, n_full = 0, n_empty = 0, n_nokey = 0;
	bit long_hold = 0;

	function automatic rsp_t predict_store(req_t r);
		rsp_t o;
		int hit;
		o = '0;
		o.status = ST_OK;
		hit = -1;
		case (r.op)
			OP_INSERT: begin
				if (stk_count >= DEPTH) begin
					o.status = ST_FULL;
				end else begin
					stk_cargo[stk_count] = r.cargo_in;
					stk_key[stk_count] = key_counter;
					stk_count++;
					o.key_out = key_counter;
					key_counter = key_counter + 1;
				end
			end
			OP_POP, OP_TAKE: begin
				if (stk_count == 0) begin
					o.status = ST_EMPTY;
				end else begin
					if (r.op == OP_POP) begin
						hit = stk_count - 1;
					end else begin
						for (int i = stk_count - 1; i >= 0; i--)
							if (hit < 0 && stk_key[i] == r.key_in) hit = i;
					end
					if (hit < 0) begin
						o.status = ST_NOKEY;
					end else begin
						o.cargo_out = stk_cargo[hit];
						for (int i = hit; i + 1 < stk_count; i++) begin
							stk_cargo[i] = stk_cargo[i + 1];
							stk_key[i] = stk_key[i + 1];
						end
						stk_count--;
					end
				end
			end
			default: ;
		endcase
		o.entries = stk_count[4:0];
		return o;
	endfunction

	// Drive one transaction and hold it until accepted. Valid stays high
	// afterwards; whoever idles the sender drops it.
	task automatic send_req(req_t r, logic has_exp, rsp_t exp_fixed);
		rsp_t p;
		p = predict_store(r);
		if (has_exp && p != exp_fixed) begin
			$error("table row disagrees with predictor: exp %h pred %h", exp_fixed, p);
			errors++;
		end
		pending_rsp.push_back(p);
		req_valid <= 1'b1;
		req <= r;
		@(posedge clk);
		while (req_stall) @(posedge clk);
	endtask

	task automatic gap_cycles();
		int g;
		g = $urandom_range(0, 19);
		if ($urandom_range(0, 3) == 0) g = 0;
		if (g > 0) begin
			req_valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
	endtask

	// A random request: mostly keys of live entries so takes hit deep in the stack.
	function automatic req_t random_req();
		req_t r;
		int sel;
		r.cargo_in = $urandom();
		r.key_in = $urandom();
		sel = $urandom_range(0, 99);
		if (sel < 45) r.op = OP_INSERT;
		else if (sel < 65) r.op = OP_POP;
		else if (sel < 97) r.op = OP_TAKE;
		else r.op = 2'd3;
		if (r.op == OP_TAKE && stk_count > 0 && $urandom_range(0, 3) != 0)
			r.key_in = stk_key[$urandom_range(0, stk_count - 1)];
		else if (r.op == OP_TAKE && $urandom_range(0, 1))
			r.key_in = key_counter + $urandom_range(0, 3);
		return r;
	endfunction

	function automatic rsp_t mk_rsp(logic [31:0] c, logic [31:0] k, logic [1:0] s,
			logic [4:0] n);
		rsp_t o;
		o.cargo_out = c;
		o.key_out = k;
		o.status = s;
		o.entries = n;
		return o;
	endfunction

	function automatic req_t mk_req(logic [1:0] op, logic [31:0] c, logic [31:0] k);
		req_t r;
		r.op = op;
		r.cargo_in = c;
		r.key_in = k;
		return r;
	endfunction

	// Result checker.
	always @(posedge clk) begin
		rsp_t e;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (pending_rsp.size() == 0) begin
				$error("unexpected result %h", rsp);
				errors++;
			end else begin
				e = pending_rsp.pop_front();
				n_rsp++;
				if (e.status == ST_FULL) n_full++;
				if (e.status == ST_EMPTY) n_empty++;
				if (e.status == ST_NOKEY) n_nokey++;
				if (rsp.cargo_out !== e.cargo_out) begin
					$error("cargo_out exp %h got %h", e.cargo_out, rsp.cargo_out);
					errors++;
				end
				if (rsp.key_out !== e.key_out) begin
					$error("key_out exp %h got %h", e.key_out, rsp.key_out);
					errors++;
				end
				if (rsp.status !== e.status) begin
					$error("status exp %0d got %0d", e.status, rsp.status);
					errors++;
				end
				if (rsp.entries !== e.entries) begin
					$error("entries exp %0d got %0d", e.entries, rsp.entries);
					errors++;
				end
			end
		end
	end

	// Receiver: random stalls per result, plus one long hold-off.
	initial begin
		int w;
		@(posedge arst_n);
		forever begin
			if (long_hold) begin
				rsp_stall <= 1'b1;
				repeat (600) @(posedge clk);
				long_hold = 0;
			end
			w = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 19);
			if (w > 0) begin
				rsp_stall <= 1'b1;
				repeat (w) @(posedge clk);
			end
			rsp_stall <= 1'b0;
			@(posedge clk);
			while (!(rsp_valid && !rsp_stall) && !long_hold) @(posedge clk);
		end
	end

	// Watchdog.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("simulation failed");
			$finish;
		end
	end

	row_t rows[$];
	rsp_t z;

	initial begin
		z = '0;
		rows.push_back('{mk_req(OP_POP, 32'hFFFFFFFF, 32'h0), 1,
			mk_rsp(0, 0, ST_EMPTY, 0)});
		rows.push_back('{mk_req(OP_TAKE, 32'h0, 32'h0), 1, mk_rsp(0, 0, ST_EMPTY, 0)});
		rows.push_back('{mk_req(2'd3, 32'hFFFFFFFF, 32'hFFFFFFFF), 1,
			mk_rsp(0, 0, ST_OK, 0)});
		rows.push_back('{mk_req(OP_INSERT, 32'hFFFFFFFF, 32'hFFFFFFFF), 1,
			mk_rsp(0, 0, ST_OK, 1)});
		rows.push_back('{mk_req(OP_INSERT, 32'h0, 32'h0), 1, mk_rsp(0, 1, ST_OK, 2)});
		rows.push_back('{mk_req(OP_TAKE, 32'h0, 32'hFFFFFFFF), 1,
			mk_rsp(0, 0, ST_NOKEY, 2)});
		rows.push_back('{mk_req(OP_TAKE, 32'h0, 32'h0), 1,
			mk_rsp(32'hFFFFFFFF, 0, ST_OK, 1)});
		for (int i = 0; i < 16; i++)
			rows.push_back('{mk_req(OP_INSERT, 32'hA5A50000 + i, 0), 0, z});
		rows.push_back('{mk_req(OP_INSERT, 32'h12345678, 0), 1, mk_rsp(0, 0, ST_FULL, 16)});
		rows.push_back('{mk_req(OP_TAKE, 0, 32'd5), 0, z});
		rows.push_back('{mk_req(OP_POP, 0, 0), 0, z});

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (rows[i]) begin
			send_req(rows[i].req, rows[i].has_exp, rows[i].exp);
			gap_cycles();
		end
		// Empty the store before the random part.
		while (stk_count > 0) send_req(mk_req(OP_POP, 0, 0), 0, z);

		for (int n = 0; n < N_RANDOM; n++) begin
			if (n == 300) begin
				// Let results pile up while the sender keeps offering.
				long_hold = 1;
			end
			if (n == 700) begin
				req_valid <= 1'b0;
				while (pending_rsp.size() > 0) @(posedge clk);
			end
			send_req(random_req(), 0, z);
			if (n % 200 < 150) gap_cycles();
		end

		req_valid <= 1'b0;
		while (pending_rsp.size() > 0) @(posedge clk);
		repeat (4 * DEPTH + 20) @(posedge clk);
		$display("covered %0d results: %0d full, %0d empty, %0d key misses",
			n_rsp, n_full, n_empty, n_nokey);
		if (errors == 0 && pending_rsp.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end
endmodule

/* files.f */
+incdir+rtl
rtl/kss_pkg.sv
rtl/kss_ram.sv
rtl/kss_ctrl.sv
rtl/keyed_stack_store.sv
rtl/kss_checker.sv
tb/sv/tb_keyed_stack_store.sv
